### rtl/core/trq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread ready queue package
// Transfer types, operation and status codes, and cell control shared by the
// queue cells and the top level.
// ----------------------------------------------------------------------------
package trq_pkg;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_PEEK   = 3'd3;
    localparam logic [2:0] OP_TEST   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [15:0] result_id;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } rsp_t;

    typedef struct packed {
        logic head_only;
        logic remove;
    } cell_ctrl_t;

endpackage

### rtl/core/trq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread ready queue cell
// Holds one queue entry, compares it against the key, passes the first hit
// down the chain and shifts in its neighbor's entry when a removal closes up.
// ----------------------------------------------------------------------------
module trq_cell #(
    parameter int ID_BITS = 16
) (
    input  logic                 clk,
    input  trq_pkg::cell_ctrl_t  ctrl,
    input  logic [ID_BITS-1:0]   key,
    input  logic                 live,
    input  logic                 load,
    input  logic [ID_BITS-1:0]   next_id,
    input  logic                 found_in,
    input  logic [ID_BITS-1:0]   res_in,
    output logic                 found_out,
    output logic [ID_BITS-1:0]   res_out,
    output logic [ID_BITS-1:0]   id_q
);
    import trq_pkg::*;

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic               hit;

    assign hit       = live && (ctrl.head_only || (id_reg == key));
    assign found_out = found_in || hit;
    assign res_out   = found_in ? res_in : (hit ? id_reg : '0);
    assign id_q      = id_reg;

    always_comb
    begin
        id_next = id_reg;
        if (load)
        begin
            id_next = key;
        end
        else if (ctrl.remove && (found_in || hit))
        begin
            id_next = next_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

### rtl/core/thread_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread ready queue
// Ordered queue of thread ids with push, pop, remove by id, peek and
// presence test, built as a row of cells with a rippling first-match chain.
// ----------------------------------------------------------------------------
// The response is registered and becomes valid in the cycle after the request transfer.
// Throughput: one operation per cycle; the request stalls only while a
// response is held by a stalled consumer.
// The cycle time is set by the first-match chain through QUEUE_DEPTH cells.
// Reset clears the entry count and the response valid; entries need no reset.
// ----------------------------------------------------------------------------
module thread_ready_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  trq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output trq_pkg::rsp_t  rsp
);
    import trq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               accept;
    logic               full;
    logic               push_ok;
    logic [ID_BITS-1:0] key;
    cell_ctrl_t         ctrl;

    logic [QUEUE_DEPTH:0]              found_c;
    logic [QUEUE_DEPTH:0][ID_BITS-1:0] res_c;
    logic [QUEUE_DEPTH-1:0][ID_BITS-1:0] id_c;
    logic [QUEUE_DEPTH-1:0]            live;
    logic [QUEUE_DEPTH-1:0]            load;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign key     = ID_BITS'(req.thread_id);
    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign push_ok = accept && (req.operation == OP_PUSH) && !full;

    assign ctrl.head_only = (req.operation == OP_POP) || (req.operation == OP_PEEK);
    assign ctrl.remove    = accept
                         && ((req.operation == OP_POP) || (req.operation == OP_REMOVE));

    assign found_c[0] = 1'b0;
    assign res_c[0]   = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [ID_BITS-1:0] nbr;

        assign live[i] = (CW'(i) < count_reg);
        assign load[i] = push_ok && (count_reg == CW'(i));

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = id_c[i+1];
        end

        trq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .key       (key),
            .live      (live[i]),
            .load      (load[i]),
            .next_id   (nbr),
            .found_in  (found_c[i]),
            .res_in    (res_c[i]),
            .found_out (found_c[i+1]),
            .res_out   (res_c[i+1]),
            .id_q      (id_c[i])
        );
    end

    always_comb
    begin
        logic [15:0] res_id;
        logic [1:0]  status;
        res_id     = '0;
        status     = ST_EMPTY;
        count_next = count_reg;
        case (req.operation)
            OP_PUSH:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_OK;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP, OP_REMOVE:
            begin
                if (found_c[QUEUE_DEPTH])
                begin
                    status     = ST_OK;
                    res_id     = 16'(res_c[QUEUE_DEPTH]);
                    count_next = count_reg - CW'(1);
                end
            end
            OP_PEEK:
            begin
                if (found_c[QUEUE_DEPTH])
                begin
                    status = ST_OK;
                    res_id = 16'(res_c[QUEUE_DEPTH]);
                end
            end
            OP_TEST:
            begin
                if (found_c[QUEUE_DEPTH])
                begin
                    status = ST_OK;
                end
            end
            default:
            begin
                status = ST_EMPTY;
            end
        endcase
        rsp_next.result_id = res_id;
        rsp_next.status    = status;
        rsp_next.occupancy = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted push did not grow the queue");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.remove && found_c[QUEUE_DEPTH]) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("successful removal did not shrink the queue");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ST_FULL)) |-> count_reg == CW'(QUEUE_DEPTH))
        else $error("full status reported on a queue that is not full");

    a_stall_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !accept)
        else $error("request taken while response is held");

endmodule
